[sv/spq_pkg.sv]
package spq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 16;
  localparam int EntryW = ValueW + PrioW;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StUnderflow = 2'd1;
  localparam logic [1:0] StOverflow  = 2'd2;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [ValueW-1:0] item_value;
    logic signed [PrioW-1:0]  item_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] removed_value;
    logic [4:0]               entry_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CMP,
    S_PUT0,
    S_RM
  } state_e;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_INSERT,
    FIN_REMOVE,
    FIN_UNDER,
    FIN_OVER
  } fin_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic rd_front;
    logic rd_top;
    logic rd_prev;
    logic wr_shift;
    logic wr_new_next;
    logic wr_new_front;
    fin_e fin;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_remove;
    logic empty;
    logic full;
    logic greater;
    logic idx_zero;
  } dp_stat_t;

endpackage

[sv/spq_datapath.sv]
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output logic     done_o,
  output result_t  result_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [EntryW-1:0] mem_q [CAPACITY];
  logic [EntryW-1:0] rdata_q;

  in_item_t item_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, done_d;
  result_t       result_q, result_d;

  logic              rd_en, wr_en;
  logic [IW-1:0]     raddr, waddr;
  logic [EntryW-1:0] wdata;
  logic [LW-1:0]     top_l;

  // logical slot to physical address, ring starting at head
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [LW-1:0] l);
    logic [LW-1:0] sum;
    sum = LW'(head) + l;
    if (sum >= LW'(CAPACITY)) begin
      sum = sum - LW'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign top_l = LW'(count_q - 1'b1);

  always_comb begin
    rd_en = cmd_i.rd_front | cmd_i.rd_top | cmd_i.rd_prev;
    raddr = phys(head_q, '0);
    if (cmd_i.rd_top) begin
      raddr = phys(head_q, top_l);
    end else if (cmd_i.rd_prev) begin
      raddr = phys(head_q, LW'(idx_q) - 1'b1);
    end

    wr_en = cmd_i.wr_shift | cmd_i.wr_new_next | cmd_i.wr_new_front;
    waddr = phys(head_q, LW'(idx_q) + 1'b1);
    wdata = {item_q.item_value, item_q.item_priority};
    if (cmd_i.wr_shift) begin
      wdata = rdata_q;
    end else if (cmd_i.wr_new_front) begin
      waddr = phys(head_q, '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    idx_d    = idx_q;
    head_d   = head_q;
    count_d  = count_q;
    done_d   = 1'b0;
    result_d = result_q;
    if (cmd_i.rd_top) begin
      idx_d = top_l[IW-1:0];
    end else if (cmd_i.rd_prev) begin
      idx_d = idx_q - 1'b1;
    end
    case (cmd_i.fin)
      FIN_INSERT: begin
        count_d = count_q + 1'b1;
        done_d  = 1'b1;
        result_d.status        = StOk;
        result_d.removed_value = '0;
        result_d.entry_count   = 5'(count_d);
      end
      FIN_REMOVE: begin
        count_d = count_q - 1'b1;
        head_d  = (LW'(head_q) + 1'b1 == LW'(CAPACITY)) ? '0 : head_q + 1'b1;
        done_d  = 1'b1;
        result_d.status        = StOk;
        result_d.removed_value = rdata_q[EntryW-1:PrioW];
        result_d.entry_count   = 5'(count_d);
      end
      FIN_UNDER: begin
        done_d = 1'b1;
        result_d.status        = StUnderflow;
        result_d.removed_value = '0;
        result_d.entry_count   = 5'(count_q);
      end
      FIN_OVER: begin
        done_d = 1'b1;
        result_d.status        = StOverflow;
        result_d.removed_value = '0;
        result_d.entry_count   = 5'(count_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign stat_o.is_remove = (item_q.command == CmdRemove);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CW'(CAPACITY));
  assign stat_o.greater   = $signed(rdata_q[PrioW-1:0]) > item_q.item_priority;
  assign stat_o.idx_zero  = (idx_q == '0);

  assign done_o   = done_q;
  assign result_o = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_en && wr_en && raddr == waddr))
    else $error("read and write hit the same slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_i.fin == FIN_REMOVE) |-> !stat_o.empty)
    else $error("remove completed on empty queue");

endmodule

[sv/spq_ctrl.sv]
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, fin: FIN_NONE};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        state_d = S_IDLE;
        if (stat_i.is_remove) begin
          if (stat_i.empty) begin
            cmd_o.fin = FIN_UNDER;
          end else begin
            cmd_o.rd_front = 1'b1;
            state_d        = S_RM;
          end
        end else if (stat_i.full) begin
          cmd_o.fin = FIN_OVER;
        end else if (stat_i.empty) begin
          cmd_o.wr_new_front = 1'b1;
          cmd_o.fin          = FIN_INSERT;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        // shift the larger entry up one slot, read the next one down meanwhile
        if (stat_i.greater) begin
          cmd_o.wr_shift = 1'b1;
          if (stat_i.idx_zero) begin
            state_d = S_PUT0;
          end else begin
            cmd_o.rd_prev = 1'b1;
          end
        end else begin
          cmd_o.wr_new_next = 1'b1;
          cmd_o.fin         = FIN_INSERT;
          state_d           = S_IDLE;
        end
      end
      S_PUT0: begin
        cmd_o.wr_new_front = 1'b1;
        cmd_o.fin          = FIN_INSERT;
        state_d            = S_IDLE;
      end
      S_RM: begin
        cmd_o.fin = FIN_REMOVE;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $onehot0({cmd_o.wr_shift, cmd_o.wr_new_next, cmd_o.wr_new_front}))
    else $error("more than one write in a cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_CMP) |-> ($past(state_q) == S_START || $past(state_q) == S_CMP))
    else $error("scan entered out of order");

endmodule

[sv/sorted_priority_queue_top.sv]
// Sorted priority queue, CAPACITY entries held in a ring buffer memory.
// Overflow, underflow and insert into an empty queue finish from S_START; remove reads
// the front, then finishes in S_RM; insert scans in S_CMP, with S_PUT0 for a new front.
// Throughput: one operation at a time, a new beat is taken at the edge that takes the
// result; an insert shifts one entry per cycle past every entry it displaces.
// Reset clears count, head and controller, not the stored entries; the strobe cannot stall.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_item_t item_i,
  output logic     done_o,
  output result_t  result_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while busy");

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int Cap       = 16;
  localparam int RandItems = 1900;
  localparam int TailWait  = 40;
  localparam int QuietMax  = 5000;

  typedef struct {
    in_item_t op;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  in_item_t item_i;
  logic     done_o;
  result_t  result_o;

  sorted_priority_queue_top #(
    .CAPACITY(Cap)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // queue contents as the block should hold them, front at index 0
  logic signed [ValueW-1:0] val_store  [Cap];
  logic signed [PrioW-1:0]  prio_store [Cap];
  int                       held;

  stim_row_t rows[$];
  result_t   awaited_results[$];
  int        taken;
  int        errors;
  int        quiet;
  int        n_directed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t pq_step(in_item_t op);
    result_t res;
    int      pos;
    res = '0;
    res.status = StOk;
    if (op.command == CmdInsert) begin
      if (held >= Cap) begin
        res.status = StOverflow;
      end else begin
        pos = 0;
        // land behind every entry of smaller or equal priority
        while (pos < held && prio_store[pos] <= op.item_priority) pos++;
        for (int i = held; i > pos; i--) begin
          val_store[i]  = val_store[i-1];
          prio_store[i] = prio_store[i-1];
        end
        val_store[pos]  = op.item_value;
        prio_store[pos] = op.item_priority;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = StUnderflow;
      end else begin
        res.removed_value = val_store[0];
        for (int i = 1; i < held; i++) begin
          val_store[i-1]  = val_store[i];
          prio_store[i-1] = prio_store[i];
        end
        held--;
      end
    end
    res.entry_count = 5'(held);
    return res;
  endfunction

  function automatic void add_row(logic cmd, logic [ValueW-1:0] val, logic [PrioW-1:0] prio,
                                  bit typed, result_t want);
    stim_row_t r;
    r.op.command       = cmd;
    r.op.item_value    = val;
    r.op.item_priority = prio;
    r.typed            = typed;
    r.want             = want;
    rows.push_back(r);
  endfunction

  function automatic logic [PrioW-1:0] rand_prio(bit narrow);
    int pick;
    pick = $urandom_range(0, 9);
    if (narrow || pick < 3) return PrioW'($urandom_range(0, 4)) - PrioW'(2);
    if (pick == 3) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    return PrioW'($urandom());
  endfunction

  function automatic void build_stimulus();
    result_t none;
    int      made;
    int      burst;
    int      mode;
    int      ins_pct;
    none = '0;
    // remove from empty, then fill with extremes and ties
    add_row(CmdRemove, 32'h1234_5678, 16'h4321, 1'b1, '{StUnderflow, 32'sd0, 5'd0});
    add_row(CmdInsert, 32'h7fff_ffff, 16'h7fff, 1'b1, '{StOk, 32'sd0, 5'd1});
    add_row(CmdInsert, 32'h8000_0000, 16'h8000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0000, 16'h0000, 1'b0, none);
    add_row(CmdInsert, 32'hffff_ffff, 16'h0000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0001, 16'h7fff, 1'b0, none);
    add_row(CmdInsert, 32'h5555_5555, 16'hffff, 1'b0, none);
    add_row(CmdInsert, 32'haaaa_aaaa, 16'h8000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0010, 16'h7ffe, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0011, 16'h4000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0012, 16'h1000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0013, 16'h0100, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0014, 16'h0001, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0015, 16'hc000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0016, 16'hf000, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0017, 16'h8001, 1'b0, none);
    add_row(CmdInsert, 32'h0000_0018, 16'h0002, 1'b0, none);
    // full: drop the item
    add_row(CmdInsert, 32'hdead_beef, 16'h8000, 1'b1, '{StOverflow, 32'sd0, 5'd16});
    add_row(CmdRemove, 32'hffff_ffff, 16'hffff, 1'b0, none);
    add_row(CmdRemove, 32'h0000_0000, 16'h0000, 1'b0, none);
    add_row(CmdRemove, 32'h0f0f_0f0f, 16'h0f0f, 1'b0, none);
    add_row(CmdInsert, 32'hcafe_f00d, 16'h8000, 1'b0, none);
    add_row(CmdRemove, 32'hf0f0_f0f0, 16'hf0f0, 1'b0, none);
    n_directed = rows.size();

    // bursts lean towards filling, draining or balance so both ends are hit often
    made = 0;
    while (made < RandItems) begin
      burst = $urandom_range(8, 48);
      mode  = $urandom_range(0, 3);
      ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (int k = 0; k < burst && made < RandItems; k++) begin
        add_row(($urandom_range(0, 99) < ins_pct) ? CmdInsert : CmdRemove,
                $urandom(), rand_prio(mode == 3), 1'b0, none);
        made++;
      end
    end
  endfunction

  function automatic int idle_pct_for(int idx);
    int r;
    r = idx - n_directed;
    if (r < RandItems / 3) return 17;
    if (r < 2 * RandItems / 3) return 80;
    return 0;
  endfunction

  task automatic send_beat(in_item_t op, int idle_pct);
    // gap first, then hold the beat until the block takes it
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start  <= 1'b1;
    item_i <= op;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    rst_ni = 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    held   = 0;
    taken  = 0;
    errors = 0;
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < rows.size(); i++) begin
      send_beat(rows[i].op, (i < n_directed) ? 17 : idle_pct_for(i));
    end
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    result_t pred;
    result_t exp_res;
    if (rst_ni) begin
      if (start && !busy) begin
        pred = pq_step(item_i);
        awaited_results.push_back(rows[taken].typed ? rows[taken].want : pred);
        taken++;
      end
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited: status %0d value %0d count %0d",
                   $time, result_o.status, result_o.removed_value, result_o.entry_count);
          errors++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (result_o.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_res.status, result_o.status);
            errors++;
          end
          if (result_o.removed_value !== exp_res.removed_value) begin
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, exp_res.removed_value, result_o.removed_value);
            errors++;
          end
          if (result_o.entry_count !== exp_res.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp_res.entry_count, result_o.entry_count);
            errors++;
          end
        end
      end
    end
  end

  // end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietMax) begin
        $display("%0t: no progress for %0d cycles", $time, QuietMax);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule
